/* design/nsss_pkg.sv */
// nsss_pkg: shared types and constants for the digit spin sequencer
// holds register index codes, the stop order and the tube control/status structs
// no dependencies
package nsss_pkg;

  localparam int TUBE_COUNT = 4;
  localparam int DIGIT_W    = 4;
  localparam int TUBE_IDX_W = 2;
  localparam int PTR_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int INTERVAL_W = 32;
  localparam int PERIOD_W   = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_INTERVAL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_STEP_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_STEP_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WRAPS_NEEDED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WRAPS_NEEDED  = 3'd4;

  // register reset values
  localparam logic [INTERVAL_W-1:0] IDLE_INTERVAL_RST      = 32'd14400000;
  localparam logic [PERIOD_W-1:0]   SHORT_STEP_PERIOD_RST  = 16'd200;
  localparam logic [PERIOD_W-1:0]   LONG_STEP_PERIOD_RST   = 16'd1000;
  localparam logic [DIGIT_W-1:0]    SHORT_WRAPS_NEEDED_RST = 4'd2;
  localparam logic [DIGIT_W-1:0]    LONG_WRAPS_NEEDED_RST  = 4'd1;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W-1:0] BLANK    = 4'hF;
  localparam logic [DIGIT_W-1:0] WRAP_MAX = 4'hF;

  // tubes stop in this order
  localparam logic [TUBE_IDX_W-1:0] STOP_ORDER [TUBE_COUNT] = '{2'd1, 2'd0, 2'd3, 2'd2};

  // control from the sequencer to each tube
  typedef struct packed {
    logic               fire;
    logic               start;
    logic               step;
    logic [DIGIT_W-1:0] needed;
  } tube_ctl_t;

  // status from each tube back to the sequencer
  typedef struct packed {
    logic [DIGIT_W-1:0] spin_next;
    logic               match;
    logic               stopped_next;
    logic               stopped;
  } tube_stat_t;

  // digits above nine show as blank
  function automatic logic [DIGIT_W-1:0] blank_digit(input logic [DIGIT_W-1:0] d);
    blank_digit = (d > DIGIT_MAX) ? BLANK : d;
  endfunction

endpackage

/* design/nixie_slot_spin_sequencer_core.sv */
// nixie_slot_spin_sequencer_core: slot-machine digit spin sequencer top level
// holds config registers, cycle timers, stop pointer and the result register
// depends on nsss_pkg and nsss_tube
//
//  channel  | signals                                          | dir
//  ---------+--------------------------------------------------+-----
//  tick in  | in_valid/in_ready, long_request, minute_*, hour_* | in
//  result   | out_valid/out_ready, display_word, cycle_active,  | out
//           | step_taken                                       |
//  config   | cfg_we, cfg_index, cfg_data                      | in
//
// one tick per clock unless a stalled result holds in_ready low; the result appears in the output
// register in the cycle after the tick transaction, set by the single pass through timers and tube logic
// a stalled result holds in_ready low until it is taken; with out_ready high
// in_ready stays high and ticks follow back to back
// rst clears the sequencer state and out_valid and loads the register defaults; result data is not reset
module nixie_slot_spin_sequencer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                long_request,
  input  logic [3:0]                          minute_tens,
  input  logic [3:0]                          minute_ones,
  input  logic [3:0]                          hour_tens,
  input  logic [3:0]                          hour_ones,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [15:0]                         display_word,
  output logic                                cycle_active,
  output logic                                step_taken,
  input  logic                                cfg_we,
  input  logic [nsss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nsss_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import nsss_pkg::*;

  // configuration registers
  logic [INTERVAL_W-1:0] idle_interval;
  logic [PERIOD_W-1:0]   short_step_period;
  logic [PERIOD_W-1:0]   long_step_period;
  logic [DIGIT_W-1:0]    short_wraps_needed;
  logic [DIGIT_W-1:0]    long_wraps_needed;

  // sequencer state
  logic                  active;
  logic                  long_mode;
  logic [PTR_W-1:0]      order_ptr;
  logic [INTERVAL_W-1:0] since_start;
  logic [PERIOD_W-1:0]   since_step;

  logic                  fire;
  logic                  start;
  logic                  step;
  logic                  active_base;
  logic                  long_mode_next;
  logic [PTR_W-1:0]      ptr_base;
  logic [PTR_W-1:0]      order_ptr_next;
  logic [INTERVAL_W-1:0] since_start_next;
  logic [PERIOD_W-1:0]   since_step_base;
  logic [PERIOD_W-1:0]   since_step_next;
  logic [PERIOD_W-1:0]   period;
  logic                  active_next;
  logic                  all_stopped;
  logic                  any_stop;
  logic [15:0]           word_next;

  logic [DIGIT_W-1:0]    now_digits [TUBE_COUNT];
  logic [TUBE_COUNT-1:0] stop;
  logic [TUBE_COUNT-1:0] stopped_vec;
  tube_ctl_t             tube_ctl;
  tube_stat_t            tube_stat [TUBE_COUNT];

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  assign now_digits[0] = minute_tens;
  assign now_digits[1] = minute_ones;
  assign now_digits[2] = hour_tens;
  assign now_digits[3] = hour_ones;

  // cycle start and step decision
  always_comb begin
    start           = long_request || (!active && (since_start >= idle_interval));
    active_base     = start || active;
    long_mode_next  = start ? long_request : long_mode;
    ptr_base        = start ? '0 : order_ptr;
    since_step_base = start ? '0 : since_step;
    period          = long_mode_next ? long_step_period : short_step_period;
    step            = active_base && (since_step_base >= period);
    tube_ctl.fire   = fire;
    tube_ctl.start  = start;
    tube_ctl.step   = step;
    tube_ctl.needed = long_mode_next ? long_wraps_needed : short_wraps_needed;
  end

  // tube lanes; only the tube at the pointer may stop on a step
  for (genvar i = 0; i < TUBE_COUNT; i++) begin : g_tube
    assign stop[i] = step && !ptr_base[PTR_W-1]
                     && (STOP_ORDER[ptr_base[TUBE_IDX_W-1:0]] == TUBE_IDX_W'(i))
                     && tube_stat[i].match;
    assign stopped_vec[i] = tube_stat[i].stopped;

    nsss_tube u_tube (
      .clk       (clk),
      .rst       (rst),
      .ctl       (tube_ctl),
      .stop      (stop[i]),
      .now_digit (now_digits[i]),
      .stat      (tube_stat[i])
    );
  end

  // end of cycle, pointer and timers
  always_comb begin
    all_stopped = 1'b1;
    for (int i = 0; i < TUBE_COUNT; i++) begin
      if (!tube_stat[i].stopped_next) begin
        all_stopped = 1'b0;
      end
    end
    any_stop       = |stop;
    order_ptr_next = ptr_base + PTR_W'(any_stop);
    active_next    = active_base && !(step && all_stopped);
    since_start_next = start ? INTERVAL_W'(1)
                     : ((since_start == '1) ? since_start : since_start + INTERVAL_W'(1));
    since_step_next  = (start || step) ? PERIOD_W'(1)
                     : ((since_step == '1) ? since_step : since_step + PERIOD_W'(1));
  end

  // display word: spinning digits while running, time otherwise
  always_comb begin
    for (int i = 0; i < TUBE_COUNT; i++) begin
      word_next[i*DIGIT_W +: DIGIT_W] =
        blank_digit(active_next ? tube_stat[i].spin_next : now_digits[i]);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_interval      <= IDLE_INTERVAL_RST;
      short_step_period  <= SHORT_STEP_PERIOD_RST;
      long_step_period   <= LONG_STEP_PERIOD_RST;
      short_wraps_needed <= SHORT_WRAPS_NEEDED_RST;
      long_wraps_needed  <= LONG_WRAPS_NEEDED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IDLE_INTERVAL:      idle_interval      <= cfg_data[INTERVAL_W-1:0];
        REG_SHORT_STEP_PERIOD:  short_step_period  <= cfg_data[PERIOD_W-1:0];
        REG_LONG_STEP_PERIOD:   long_step_period   <= cfg_data[PERIOD_W-1:0];
        REG_SHORT_WRAPS_NEEDED: short_wraps_needed <= cfg_data[DIGIT_W-1:0];
        REG_LONG_WRAPS_NEEDED:  long_wraps_needed  <= cfg_data[DIGIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      long_mode   <= 1'b0;
      order_ptr   <= '0;
      since_start <= '0;
      since_step  <= '0;
    end else if (fire) begin
      active      <= active_next;
      long_mode   <= long_mode_next;
      order_ptr   <= order_ptr_next;
      since_start <= since_start_next;
      since_step  <= since_step_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      display_word <= word_next;
      cycle_active <= active_next;
      step_taken   <= step;
    end
  end

  // checks
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    order_ptr <= PTR_W'(TUBE_COUNT))
    else $error("stop pointer beyond tube count");

  a_ptr_counts_stops: assert property (@(posedge clk) disable iff (rst)
    $countones(stopped_vec) == 32'(order_ptr))
    else $error("stop pointer disagrees with stopped tubes");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (order_ptr == PTR_W'(TUBE_COUNT)) |-> !active)
    else $error("cycle still active with every tube stopped");

  a_result_flag: assert property (@(posedge clk) disable iff (rst)
    fire |=> (out_valid && (cycle_active == active)))
    else $error("result active flag differs from state");

endmodule

/* design/nsss_tube.sv */
// nsss_tube: state of one spinning tube (digit, wrap count, target, stopped)
// depends on nsss_pkg
module nsss_tube (
  input  logic                              clk,
  input  logic                              rst,
  input  nsss_pkg::tube_ctl_t               ctl,
  input  logic                              stop,
  input  logic [nsss_pkg::DIGIT_W-1:0]      now_digit,
  output nsss_pkg::tube_stat_t              stat
);
  import nsss_pkg::*;

  logic [DIGIT_W-1:0] spin;
  logic [DIGIT_W-1:0] wraps;
  logic [DIGIT_W-1:0] target;
  logic               stopped;

  logic [DIGIT_W-1:0] spin_base;
  logic [DIGIT_W-1:0] wraps_base;
  logic [DIGIT_W-1:0] target_next;
  logic               stopped_base;
  logic [DIGIT_W-1:0] spin_next;
  logic [DIGIT_W-1:0] wraps_next;
  logic               stopped_next;

  // cycle start clears the tube and latches the target
  always_comb begin
    spin_base    = ctl.start ? '0 : spin;
    wraps_base   = ctl.start ? '0 : wraps;
    stopped_base = ctl.start ? 1'b0 : stopped;
    target_next  = ctl.start ? now_digit : target;
  end

  // advance the digit on a step, counting wraps with saturation
  always_comb begin
    spin_next  = spin_base;
    wraps_next = wraps_base;
    if (ctl.step && !stopped_base) begin
      if (spin_base >= DIGIT_MAX) begin
        spin_next = '0;
        if (wraps_base != WRAP_MAX) begin
          wraps_next = wraps_base + DIGIT_W'(1);
        end
      end else begin
        spin_next = spin_base + DIGIT_W'(1);
      end
    end
    stopped_next = stopped_base | stop;
  end

  // status for the stop decision and display
  always_comb begin
    stat.spin_next    = stop ? target_next : spin_next;
    stat.match        = (wraps_next >= ctl.needed) && (spin_next == target_next);
    stat.stopped_next = stopped_next;
    stat.stopped      = stopped;
  end

  // tube registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spin    <= '0;
      wraps   <= '0;
      target  <= '0;
      stopped <= 1'b0;
    end else if (ctl.fire) begin
      spin    <= spin_next;
      wraps   <= wraps_next;
      target  <= target_next;
      stopped <= stopped_next;
    end
  end

endmodule

/* tb/sv/testbench.sv */
// testbench for nixie_slot_spin_sequencer_core: tick stream in, display results out
// a scoreboard class predicts every result from its own copy of the sequencer state
// depends on nsss_pkg and the core under test
module testbench;
  import nsss_pkg::*;

  // one display result as the core presents it
  typedef struct packed {
    logic [15:0] display;
    logic        active;
    logic        stepped;
  } spin_result_t;

  // spin sequencer prediction and result checking
  class spin_scoreboard;
    logic [31:0]  idle_interval;
    logic [15:0]  short_period;
    logic [15:0]  long_period;
    logic [3:0]   short_wraps;
    logic [3:0]   long_wraps;
    logic [3:0]   spin [TUBE_COUNT];
    logic [3:0]   target [TUBE_COUNT];
    logic [3:0]   wraps [TUBE_COUNT];
    bit           stopped [TUBE_COUNT];
    logic [2:0]   stop_ptr;
    bit           active;
    bit           long_mode;
    logic [31:0]  since_start;
    logic [15:0]  since_step;
    spin_result_t expected_q [$];
    int unsigned  errors;

    function new();
      idle_interval = IDLE_INTERVAL_RST;
      short_period  = SHORT_STEP_PERIOD_RST;
      long_period   = LONG_STEP_PERIOD_RST;
      short_wraps   = SHORT_WRAPS_NEEDED_RST;
      long_wraps    = LONG_WRAPS_NEEDED_RST;
      for (int i = 0; i < TUBE_COUNT; i++) begin
        spin[i]    = '0;
        target[i]  = '0;
        wraps[i]   = '0;
        stopped[i] = 1'b0;
      end
      stop_ptr    = '0;
      active      = 1'b0;
      long_mode   = 1'b0;
      since_start = '0;
      since_step  = '0;
      errors      = 0;
    endfunction

    // mirror of a register write
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IDLE_INTERVAL:      idle_interval = data;
        REG_SHORT_STEP_PERIOD:  short_period  = data[15:0];
        REG_LONG_STEP_PERIOD:   long_period   = data[15:0];
        REG_SHORT_WRAPS_NEEDED: short_wraps   = data[3:0];
        REG_LONG_WRAPS_NEEDED:  long_wraps    = data[3:0];
        default: ;
      endcase
    endfunction

    // advance the sequencer by one accepted tick and queue its display result
    function void note_tick(bit req, logic [15:0] digits);
      logic [15:0]  period;
      logic [3:0]   need;
      logic [1:0]   tube;
      logic [3:0]   shown;
      bit           stepped;
      bit           all_stopped;
      spin_result_t res;
      stepped = 1'b0;

      // automatic start when idle long enough, or a long request at any time
      if ((!active && since_start >= idle_interval) || req) begin
        long_mode   = req;
        active      = 1'b1;
        since_start = '0;
        since_step  = '0;
        for (int i = 0; i < TUBE_COUNT; i++) begin
          target[i]  = digits[4*i +: 4];
          spin[i]    = '0;
          stopped[i] = 1'b0;
          wraps[i]   = '0;
        end
        stop_ptr = '0;
      end

      // step the spinning digits and try to stop the next tube in order
      if (active) begin
        period = long_mode ? long_period : short_period;
        need   = long_mode ? long_wraps : short_wraps;
        if (since_step >= period) begin
          stepped    = 1'b1;
          since_step = '0;
          for (int i = 0; i < TUBE_COUNT; i++) begin
            if (!stopped[i]) begin
              if (spin[i] >= DIGIT_MAX) begin
                spin[i] = '0;
                if (wraps[i] < WRAP_MAX) wraps[i]++;
              end else begin
                spin[i]++;
              end
            end
          end
          if (stop_ptr < 3'd4) begin
            tube = STOP_ORDER[stop_ptr[1:0]];
            if (wraps[tube] >= need && spin[tube] == target[tube]) begin
              stopped[tube] = 1'b1;
              stop_ptr++;
            end
          end
          all_stopped = 1'b1;
          for (int i = 0; i < TUBE_COUNT; i++)
            if (!stopped[i]) all_stopped = 1'b0;
          if (all_stopped) active = 1'b0;
        end
      end

      // saturating tick counters
      if (since_start != 32'hFFFF_FFFF) since_start++;
      if (since_step != 16'hFFFF) since_step++;

      // display word, blanking anything above nine
      for (int i = 0; i < TUBE_COUNT; i++) begin
        shown = active ? spin[i] : digits[4*i +: 4];
        res.display[4*i +: 4] = (shown > DIGIT_MAX) ? BLANK : shown;
      end
      res.active  = active;
      res.stepped = stepped;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [15:0] word, logic act, logic stp);
      spin_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("unexpected result: display_word %h cycle_active %b step_taken %b",
               word, act, stp);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (word !== exp_res.display) begin
        $error("display_word: expected %h, actual %h", exp_res.display, word);
        errors++;
      end
      if (act !== exp_res.active) begin
        $error("cycle_active: expected %b, actual %b", exp_res.active, act);
        errors++;
      end
      if (stp !== exp_res.stepped) begin
        $error("step_taken: expected %b, actual %b", exp_res.stepped, stp);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  long_request = 1'b0;
  logic [3:0]            minute_tens = '0;
  logic [3:0]            minute_ones = '0;
  logic [3:0]            hour_tens = '0;
  logic [3:0]            hour_ones = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [15:0]           display_word;
  logic                  cycle_active;
  logic                  step_taken;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  spin_scoreboard sb = new();
  int unsigned    burst_left = 0;
  bit             hold_req = 1'b0;

  nixie_slot_spin_sequencer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .long_request (long_request),
    .minute_tens  (minute_tens),
    .minute_ones  (minute_ones),
    .hour_tens    (hour_tens),
    .hour_ones    (hour_ones),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .display_word (display_word),
    .cycle_active (cycle_active),
    .step_taken   (step_taken),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // result transactions go straight to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(display_word, cycle_active, step_taken);
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin : result_sink
    int unsigned cyc;
    int unsigned mode;
    bit [7:0]    mask;
    bit          hold_done;
    cyc       = 0;
    mode      = 0;
    mask      = '1;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
      end
      if (cyc % 16 == 0) begin
        mode = $urandom_range(0, 3);
        mask = 8'($urandom_range(0, 255));
      end
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= mask[cyc % 8];
      endcase
      cyc++;
    end
  end

  // one tick transaction, with burst and gap shaping on the sender side
  task automatic send_tick(input bit req, input logic [15:0] digits);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    long_request <= req;
    minute_tens  <= digits[3:0];
    minute_ones  <= digits[7:4];
    hour_tens    <= digits[11:8];
    hour_ones    <= digits[15:12];
    do @(posedge clk); while (!in_ready);
    sb.note_tick(req, digits);
  endtask

  // stop sending until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // register set for one phase, written only with the core drained
  task automatic load_config(input logic [31:0] idle, input logic [15:0] sp,
                             input logic [15:0] lp, input logic [3:0] sw,
                             input logic [3:0] lw);
    wait_drained();
    repeat (3) @(posedge clk);
    write_reg(REG_IDLE_INTERVAL, idle);
    write_reg(REG_SHORT_STEP_PERIOD, {16'h0, sp});
    write_reg(REG_LONG_STEP_PERIOD, {16'h0, lp});
    write_reg(REG_SHORT_WRAPS_NEEDED, {28'h0, sw});
    write_reg(REG_LONG_WRAPS_NEEDED, {28'h0, lw});
    cfg_we <= 1'b0;
  endtask

  // mostly valid time digits, now and then one above nine
  function automatic logic [15:0] random_digits(int unsigned wild_odds);
    logic [15:0] d;
    for (int i = 0; i < TUBE_COUNT; i++)
      d[4*i +: 4] = ($urandom_range(0, wild_odds - 1) == 0) ? 4'($urandom_range(10, 15))
                                                           : 4'($urandom_range(0, 9));
    return d;
  endfunction

  task automatic run_random(input int unsigned items, input int unsigned req_odds,
                            input int unsigned wild_odds, input int hold_at,
                            input int pause_at);
    for (int n = 0; n < items; n++) begin
      if (n == hold_at) hold_req = 1'b1;
      if (n == pause_at) wait_drained();
      send_tick($urandom_range(0, req_odds - 1) == 0, random_digits(wild_odds));
    end
  endtask

  // stimulus
  initial begin : stimulus
    logic [16:0] directed [18];
    directed = '{17'h0_0000, 17'h1_9999, 17'h0_FFFF, 17'h1_AAAA, 17'h0_5555,
                 17'h1_ABCD, 17'h1_1234, 17'h0_9876, 17'h0_0F0F, 17'h0_F0F0,
                 17'h0_3210, 17'h1_0000, 17'h0_6789, 17'h0_9090, 17'h0_0909,
                 17'h1_0000, 17'h0_EDCB, 17'h0_4521};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values: huge idle interval, long cycle with slow steps
    send_tick(1'b0, 16'h0000);
    send_tick(1'b0, 16'h9999);
    send_tick(1'b1, 16'h4321);
    send_tick(1'b0, 16'hFFFF);

    // directed ticks with fast steps and no wraps needed
    load_config(32'd1, 16'd1, 16'd2, 4'd0, 4'd0);
    foreach (directed[k])
      send_tick(directed[k][16], directed[k][15:0]);

    load_config(32'd5, 16'd1, 16'd1, 4'd0, 4'd1);
    run_random(150, 16, 16, 40, -1);

    load_config(32'd1, 16'd2, 16'd3, 4'd1, 4'd0);
    run_random(150, 24, 24, -1, 75);

    // automatic cycles never come, long cycles run at full speed
    load_config(32'hFFFF_FFFF, 16'hFFFF, 16'd1, 4'd15, 4'd2);
    run_random(150, 25, 20, -1, -1);

    load_config(32'd30, 16'd1, 16'hFFFF, 4'd3, 4'd15);
    run_random(150, 400, 32, -1, -1);

    load_config(32'd1, 16'd1, 16'd1, 4'd15, 4'd15);
    run_random(150, 300, 64, -1, -1);

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[nixie_slot_spin_sequencer_core] OK");
    end else begin
      $display("[nixie_slot_spin_sequencer_core] ERROR");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("[nixie_slot_spin_sequencer_core] ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/nsss_pkg.sv
design/nsss_tube.sv
design/nixie_slot_spin_sequencer_core.sv
tb/sv/testbench.sv
